// ----- hw/rtl/key_click_detector_top_defines.svh -----
// Assertion macros used by the key click detector merge stage.
`ifndef KEY_CLICK_DETECTOR_TOP_DEFINES_SVH
`define KEY_CLICK_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication under synchronous active-low reset.
`define KCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key click detector check failed");
// Next-cycle implication under synchronous active-low reset.
`define KCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key click detector check failed");
`else
`define KCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/kcd_pkg.sv -----
// Shared constants, types and codes of the key click detector.
package kcd_pkg;

    localparam int KEY_LEVEL_W   = 4;
    localparam int TIME_IN_W     = 32;
    localparam int KEY_NUM_W     = 2;
    localparam int EVENT_W       = 2;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_EVENTS    = 4;
    localparam int SENT_W        = $clog2(MAX_EVENTS);

    localparam int NUM_KEYS_DEF  = 4;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd10;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd300;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd800;

    typedef enum logic [EVENT_W-1:0] {
        EV_SHORT  = 2'd0,
        EV_DOUBLE = 2'd1,
        EV_LONG   = 2'd2
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_WINDOW   = 2'd1,
        CFG_LONG     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] double_window_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic   hit;
        t_event kind;
    } t_lane_ev;

    typedef struct packed {
        logic [KEY_NUM_W-1:0] key_number;
        t_event               event_kind;
        logic                 last_event;
    } t_evt;

endpackage

// ----- hw/rtl/kcd_scan_if.sv -----
// Scan channel: raw key levels and timestamp, valid/ready handshake.
interface kcd_scan_if;
    logic                              valid;
    logic                              ready;
    logic [kcd_pkg::KEY_LEVEL_W-1:0]   key_levels;
    logic [kcd_pkg::TIME_IN_W-1:0]     now_ms;

    modport source (output valid, key_levels, now_ms, input ready);
    modport sink   (input valid, key_levels, now_ms, output ready);
endinterface

// ----- hw/rtl/kcd_event_if.sv -----
// Event channel: one key event per transaction, valid/ready handshake.
interface kcd_event_if;
    logic                              valid;
    logic                              ready;
    logic [kcd_pkg::KEY_NUM_W-1:0]     key_number;
    logic [kcd_pkg::EVENT_W-1:0]       event_kind;
    logic                              last_event;

    modport source (output valid, key_number, event_kind, last_event, input ready);
    modport sink   (input valid, key_number, event_kind, last_event, output ready);
endinterface

// ----- hw/rtl/kcd_lane.sv -----
// One key lane: press state machine, time stamps and event detection.
module kcd_lane #(
    parameter int TIME_BITS = kcd_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_pressed,
    input  logic [TIME_BITS-1:0] i_now,
    input  kcd_pkg::t_cfg        i_cfg,
    output kcd_pkg::t_lane_ev    o_ev
);
    import kcd_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE         = 6'b000001,
        PH_DEB_PRESS    = 6'b000010,
        PH_CONFIRMED    = 6'b000100,
        PH_WAIT_SECOND  = 6'b001000,
        PH_DEB_SECOND   = 6'b010000,
        PH_WAIT_RELEASE = 6'b100000
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_change_stamp, r_press_stamp, r_release_stamp;
    logic                 w_set_change, w_set_press, w_set_release;
    logic [TIME_BITS-1:0] w_stamp, w_elapsed;
    logic [CFG_W-1:0]     w_thr;
    logic                 w_due;

    // Only one stamp and one limit matter in each phase, so one subtract
    // and compare serve all timeouts.
    always_comb begin
        unique case (r_phase)
            PH_CONFIRMED: begin
                w_stamp = r_press_stamp;
                w_thr   = i_cfg.long_press_ms;
            end
            PH_WAIT_SECOND: begin
                w_stamp = r_release_stamp;
                w_thr   = i_cfg.double_window_ms;
            end
            default: begin
                w_stamp = r_change_stamp;
                w_thr   = i_cfg.debounce_ms;
            end
        endcase
    end

    assign w_elapsed = i_now - w_stamp;
    assign w_due     = (w_elapsed >= TIME_BITS'(w_thr));

    always_comb begin
        n_phase       = r_phase;
        w_set_change  = 1'b0;
        w_set_press   = 1'b0;
        w_set_release = 1'b0;
        o_ev.hit      = 1'b0;
        o_ev.kind     = EV_SHORT;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_pressed) begin
                    w_set_change = 1'b1;
                    n_phase      = PH_DEB_PRESS;
                end
            end
            PH_DEB_PRESS: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                end else if (w_due) begin
                    w_set_press = 1'b1;
                    n_phase     = PH_CONFIRMED;
                end
            end
            PH_CONFIRMED: begin
                if (!i_pressed) begin
                    w_set_release = 1'b1;
                    n_phase       = PH_WAIT_SECOND;
                end else if (w_due) begin
                    n_phase   = PH_WAIT_RELEASE;
                    o_ev.hit  = 1'b1;
                    o_ev.kind = EV_LONG;
                end
            end
            PH_WAIT_SECOND: begin
                if (i_pressed) begin
                    w_set_change = 1'b1;
                    n_phase      = PH_DEB_SECOND;
                end else if (w_due) begin
                    n_phase   = PH_IDLE;
                    o_ev.hit  = 1'b1;
                    o_ev.kind = EV_SHORT;
                end
            end
            PH_DEB_SECOND: begin
                if (!i_pressed) begin
                    n_phase = PH_WAIT_SECOND;
                end else if (w_due) begin
                    n_phase   = PH_WAIT_RELEASE;
                    o_ev.hit  = 1'b1;
                    o_ev.kind = EV_DOUBLE;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_set_change) begin
            r_change_stamp <= i_now;
        end
        if (i_step && w_set_press) begin
            r_press_stamp <= i_now;
        end
        if (i_step && w_set_release) begin
            r_release_stamp <= i_now;
        end
    end

endmodule

// ----- hw/rtl/kcd_merge.sv -----
// Merge stage: serializes the lane events of a scan in key order.
`include "key_click_detector_top_defines.svh"
module kcd_merge #(
    parameter int NUM_KEYS = kcd_pkg::NUM_KEYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  kcd_pkg::t_lane_ev i_lane [NUM_KEYS],
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output kcd_pkg::t_evt     o_out
);
    import kcd_pkg::*;

    logic [NUM_KEYS-1:0]  r_pend, n_pend, w_rest, w_hits;
    t_event               r_kind [NUM_KEYS];
    logic [SENT_W-1:0]    r_sent, n_sent;
    logic                 r_ovalid;
    t_evt                 r_out;
    logic [KEY_NUM_W-1:0] w_key;
    t_event               w_kind;
    logic                 w_move, w_last;

    // Lowest pending key wins.
    always_comb begin
        w_key  = '0;
        w_kind = EV_SHORT;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                w_key  = KEY_NUM_W'(k);
                w_kind = r_kind[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_hits[k] = i_lane[k].hit;
        end
    end

    assign w_rest = r_pend & (r_pend - NUM_KEYS'(1));
    assign w_move = (|r_pend) && (!r_ovalid || i_out_ready);
    // The event that fills the last result slot ends the scan; the rest drop.
    assign w_last = (w_rest == '0) || (r_sent == SENT_W'(MAX_EVENTS - 1));
    assign o_in_ready = (r_pend == '0) || (w_move && w_last);

    always_comb begin
        n_pend = r_pend;
        n_sent = r_sent;
        if (i_load) begin
            n_pend = w_hits;
            n_sent = '0;
        end else if (w_move) begin
            n_pend = w_last ? '0 : w_rest;
            n_sent = r_sent + SENT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_sent   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_sent <= n_sent;
            if (w_move) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_kind[k] <= i_lane[k].kind;
            end
        end
        if (w_move) begin
            r_out.key_number <= w_key;
            r_out.event_kind <= w_kind;
            r_out.last_event <= w_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    `KCD_ASSERT_IMPLY(a_more_pending, i_clk, i_rst_n, r_ovalid && !r_out.last_event, r_pend != '0)
    `KCD_ASSERT_NEXT(a_load_restarts, i_clk, i_rst_n, i_load, r_sent == '0)
    `KCD_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, w_move && w_last && !i_load, r_pend == '0)

endmodule

// ----- hw/rtl/key_click_detector_top.sv -----
// Top level of the key click detector: configuration, key lanes and merge stage.
//
// The key click detector takes one scan per transaction on i_scan (raw
// active-low key levels and a millisecond timestamp) and reports short,
// double and long presses per key on o_event, one event per transaction, in
// ascending key order, with last_event set on the final event of the scan;
// a scan that completes no press gives no transaction at all, and at most
// four events leave per scan. Every key has its own lane, and all lanes
// update in the cycle a scan is accepted. The pending events are then
// moved one per cycle through the output register while o_event is not
// stalled, and the next scan is accepted in the same cycle as the previous
// scan's last event enters the output register. The first event of a scan
// is registered in the pending set and then in the output register before
// it shows on o_event. Timeouts compare the wrapped timestamp difference
// against the configuration value with ">=".
// Configuration registers (index: debounce 0, double window 1, long press 2)
// are written through i_cfg_we and should only change while no scan is in
// flight; writes to other indexes are ignored. Keys beyond the four level
// bits read as pressed.
module key_click_detector_top #(
    parameter int NUM_KEYS  = kcd_pkg::NUM_KEYS_DEF,
    parameter int TIME_BITS = kcd_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kcd_pkg::CFG_W-1:0]     i_cfg_data,
    kcd_scan_if.sink                      i_scan,
    kcd_event_if.source                   o_event
);
    import kcd_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_accept;
    logic [TIME_BITS-1:0] w_now;
    t_lane_ev             w_lane [NUM_KEYS];
    logic                 w_in_ready;
    logic                 w_out_valid;
    t_evt                 w_out;

    // Configuration registers. Unknown indexes fall through untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= DEBOUNCE_RST;
            r_cfg.double_window_ms <= WINDOW_RST;
            r_cfg.long_press_ms    <= LONG_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE: r_cfg.debounce_ms      <= i_cfg_data;
                CFG_WINDOW:   r_cfg.double_window_ms <= i_cfg_data;
                CFG_LONG:     r_cfg.long_press_ms    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A transaction on the scan channel steps every lane at once.
    assign w_accept     = i_scan.valid && w_in_ready;
    assign i_scan.ready = w_in_ready;
    assign w_now        = i_scan.now_ms[TIME_BITS-1:0];

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic w_pressed;
        if (k < KEY_LEVEL_W) begin : g_pin
            assign w_pressed = ~i_scan.key_levels[k];
        end else begin : g_nopin
            assign w_pressed = 1'b1;
        end

        kcd_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (w_accept),
            .i_pressed (w_pressed),
            .i_now     (w_now),
            .i_cfg     (r_cfg),
            .o_ev      (w_lane[k])
        );
    end

    kcd_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_lane      (w_lane),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_event.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign o_event.valid      = w_out_valid;
    assign o_event.key_number = w_out.key_number;
    assign o_event.event_kind = w_out.event_kind;
    assign o_event.last_event = w_out.last_event;

endmodule
